// File: hw/rtl/nse_pkg.sv
// Shared types and constants for the nodewise scaled error maximum block.
package nse_pkg;

	localparam int DATA_W = 48;
	localparam int SUM_W = 96;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [DATA_W-1:0] ABS_TOL_RESET = 48'd281474977;
	localparam logic [DATA_W-1:0] REL_TOL_RESET = 48'd281474976711;

	localparam logic CFG_ABS_TOL = 1'b0;
	localparam logic CFG_REL_TOL = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] err_x;
		logic signed [DATA_W-1:0] err_y;
		logic signed [DATA_W-1:0] err_z;
		logic signed [DATA_W-1:0] mag_x;
		logic signed [DATA_W-1:0] mag_y;
		logic signed [DATA_W-1:0] mag_z;
		logic last_node;
	} node_t;

	typedef struct packed {
		logic [DATA_W-1:0] scaled_error_max;
		logic saturated;
	} res_t;

	// sums of squares for one node, handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] err_sum;
		logic [SUM_W-1:0] mag_sum;
		logic last;
	} work_t;

endpackage

// File: hw/rtl/nse_front.sv
// Front: accepts a node item and forms both sums of squares with a shared 24x24 multiplier.
module nse_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           node_valid,
	output logic           node_stall,
	input  nse_pkg::node_t node,
	output logic           push,
	output nse_pkg::work_t work,
	input  logic           full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HH = 2'd2;
	localparam logic [2:0] COMP_LAST = 3'd5;
	localparam logic [2:0] ERR_COMPS = 3'd3;

	fstate_t state_q;
	logic [2:0] comp_q;
	logic [1:0] ph_q;
	logic [47:0] mag_q [6];
	logic [95:0] esum_q, msum_q;
	logic last_q;
	logic [23:0] mul_a, mul_b;
	logic [47:0] prod;
	logic [95:0] addend;
	logic accept;

	function automatic logic [47:0] mag48(input logic [47:0] v);
		mag48 = v[47] ? (~v + 48'd1) : v;
	endfunction

	assign node_stall = (state_q != F_IDLE);
	assign accept = node_valid && !node_stall;
	assign push = (state_q == F_PUSH) && !full;
	assign work = '{err_sum: esum_q, mag_sum: msum_q, last: last_q};

	always_comb begin
		mul_a = (ph_q == PH_HH) ? mag_q[0][47:24] : mag_q[0][23:0];
		mul_b = (ph_q == PH_LL) ? mag_q[0][23:0] : mag_q[0][47:24];
		prod = 48'(mul_a * mul_b);
		case (ph_q)
			PH_LL: addend = {48'd0, prod};
			PH_LH: addend = {23'd0, prod, 25'd0};
			PH_HH: addend = {prod, 48'd0};
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			comp_q <= '0;
			ph_q <= PH_LL;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_MUL;
						comp_q <= '0;
						ph_q <= PH_LL;
					end
				end
				F_MUL: begin
					if (ph_q == PH_HH) begin
						ph_q <= PH_LL;
						comp_q <= comp_q + 3'd1;
						if (comp_q == COMP_LAST)
							state_q <= F_PUSH;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q[0] <= mag48(node.err_x);
			mag_q[1] <= mag48(node.err_y);
			mag_q[2] <= mag48(node.err_z);
			mag_q[3] <= mag48(node.mag_x);
			mag_q[4] <= mag48(node.mag_y);
			mag_q[5] <= mag48(node.mag_z);
			last_q <= node.last_node;
			esum_q <= '0;
			msum_q <= '0;
		end else if (state_q == F_MUL) begin
			if (comp_q < ERR_COMPS)
				esum_q <= esum_q + addend;
			else
				msum_q <= msum_q + addend;
			if (ph_q == PH_HH) begin
				for (int i = 0; i < 5; i++)
					mag_q[i] <= mag_q[i+1];
			end
		end
	end

endmodule

// File: hw/rtl/nse_fifo.sv
// Small register queue between front and back.
module nse_fifo #(
	parameter int DEPTH = nse_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nse_pkg::work_t wdata,
	output logic           full,
	input  logic           pop,
	output nse_pkg::work_t rdata,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nse_pkg::work_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// File: hw/rtl/nse_back.sv
// Back: square roots, scale, bit-serial divide and running maximum with result register.
module nse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [47:0]    abs_tol,
	input  logic [47:0]    rel_tol,
	input  logic           empty,
	output logic           pop,
	input  nse_pkg::work_t wdata,
	output logic           res_valid,
	input  logic           res_stall,
	output nse_pkg::res_t  res
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SQRT = 5'b00010,
		B_MULT = 5'b00100,
		B_DIV  = 5'b01000,
		B_DONE = 5'b10000
	} bstate_t;

	localparam logic [6:0] SQRT_LAST = 7'd47;
	localparam logic [6:0] DIV_TOP = 7'd82;
	localparam logic [6:0] Q_BITS = 7'd48;
	localparam logic [1:0] MULT_LAST = 2'd3;
	localparam logic [47:0] ONE_Q45 = 48'h2000_0000_0000;

	bstate_t state_q;
	logic [6:0] cnt_q;
	logic [95:0] erad_q, mrad_q;
	logic [51:0] erem_q, mrem_q;
	logic [47:0] eroot_q, mroot_q;
	logic last_q;
	logic [95:0] pacc_q;
	logic [51:0] scale_q;
	logic [82:0] num_q;
	logic [52:0] drem_q;
	logic [47:0] quo_q;
	logic dsat_q;
	logic [47:0] max_q;
	logic sat_q;
	logic res_valid_q;
	nse_pkg::res_t res_q;

	logic [99:0] estep, mstep;
	logic [47:0] floored;
	logic [23:0] mul_a, mul_b;
	logic [47:0] prod;
	logic [95:0] addend;
	logic [52:0] dtrial;
	logic dfit;
	logic [47:0] ratio;
	logic [47:0] new_max;
	logic new_sat;
	logic out_free, leave;

	// one restoring square root digit: returns {rem, root}
	function automatic logic [99:0] sqrt_step(input logic [51:0] rem, input logic [47:0] root,
	                                          input logic [1:0] two);
		logic [51:0] sh;
		logic [51:0] trial;
		sh = {rem[49:0], two};
		trial = {2'b00, root, 2'b01};
		if (sh >= trial)
			sqrt_step = {sh - trial, root[46:0], 1'b1};
		else
			sqrt_step = {sh, root[46:0], 1'b0};
	endfunction

	assign estep = sqrt_step(erem_q, eroot_q, erad_q[95:94]);
	assign mstep = sqrt_step(mrem_q, mroot_q, mrad_q[95:94]);
	assign floored = (mroot_q < ONE_Q45) ? ONE_Q45 : mroot_q;

	always_comb begin
		mul_a = cnt_q[1] ? rel_tol[47:24] : rel_tol[23:0];
		mul_b = cnt_q[0] ? floored[47:24] : floored[23:0];
		prod = 48'(mul_a * mul_b);
		case (cnt_q[1:0])
			2'd0: addend = {48'd0, prod};
			2'd1, 2'd2: addend = {24'd0, prod, 24'd0};
			2'd3: addend = {prod, 48'd0};
			default: addend = '0;
		endcase
	end

	assign dtrial = {drem_q[51:0], num_q[82]};
	assign dfit = (dtrial >= {1'b0, scale_q});

	assign ratio = dsat_q ? '1 : quo_q;
	assign new_max = (ratio > max_q) ? ratio : max_q;
	assign new_sat = sat_q | dsat_q;
	assign out_free = !res_valid_q || !res_stall;
	assign leave = (state_q == B_DONE) && (!last_q || out_free);
	assign pop = (state_q == B_IDLE) && !empty;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= '0;
			max_q <= '0;
			sat_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (leave && last_q)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_SQRT;
						cnt_q <= '0;
					end
				end
				B_SQRT: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == SQRT_LAST) begin
						state_q <= B_MULT;
						cnt_q <= '0;
					end
				end
				B_MULT: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == MULT_LAST) begin
						state_q <= B_DIV;
						cnt_q <= DIV_TOP;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (scale_q == '0 || cnt_q == '0)
						state_q <= B_DONE;
				end
				B_DONE: begin
					if (leave) begin
						state_q <= B_IDLE;
						if (last_q) begin
							max_q <= '0;
							sat_q <= 1'b0;
						end else begin
							max_q <= new_max;
							sat_q <= new_sat;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				erad_q <= wdata.err_sum;
				mrad_q <= wdata.mag_sum;
				last_q <= wdata.last;
				erem_q <= '0;
				mrem_q <= '0;
				eroot_q <= '0;
				mroot_q <= '0;
				pacc_q <= '0;
			end
			B_SQRT: begin
				erad_q <= {erad_q[93:0], 2'b00};
				mrad_q <= {mrad_q[93:0], 2'b00};
				{erem_q, eroot_q} <= estep;
				{mrem_q, mroot_q} <= mstep;
			end
			B_MULT: begin
				pacc_q <= pacc_q + addend;
				// scale uses the finished product on the last partial product
				if (cnt_q[1:0] == MULT_LAST)
					scale_q <= {4'd0, abs_tol} + {1'b0, 51'((pacc_q + addend) >> 45)};
				num_q <= {eroot_q, 35'd0};
				drem_q <= '0;
				quo_q <= '0;
				dsat_q <= 1'b0;
			end
			B_DIV: begin
				num_q <= {num_q[81:0], 1'b0};
				if (scale_q != '0) begin
					drem_q <= dfit ? dtrial - {1'b0, scale_q} : dtrial;
					quo_q <= {quo_q[46:0], dfit};
					if (dfit && cnt_q >= Q_BITS)
						dsat_q <= 1'b1;
				end
			end
			B_DONE: begin
				if (leave && last_q) begin
					res_q.scaled_error_max <= new_max;
					res_q.saturated <= new_sat;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/nodewise_scaled_error_max.sv
// Top level: tolerance registers, front, queue and back of the nodewise scaled error maximum.
// Steps: the front forms 18 partial products; the back runs 48 square root steps, 4 partial products,
// up to 83 divide steps and an update, plus queue hand-off.
// Flow: the back's bit-serial root and divider set the pace; the front takes new node items until the queue is full.
// Result register: a finished result waits there while the next items are taken.
// Reset: arst_n clears all control, the running maximum and the flag, and loads default tolerances.
module nodewise_scaled_error_max #(
	parameter int QUEUE_DEPTH = nse_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           node_valid,
	output logic           node_stall,
	input  nse_pkg::node_t node,
	output logic           res_valid,
	input  logic           res_stall,
	output nse_pkg::res_t  res,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [47:0]    cfg_data
);

	logic [47:0] abs_tol_q, rel_tol_q;
	logic push, full, pop, empty;
	nse_pkg::work_t wr_work, rd_work;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_tol_q <= nse_pkg::ABS_TOL_RESET;
			rel_tol_q <= nse_pkg::REL_TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nse_pkg::CFG_ABS_TOL: abs_tol_q <= cfg_data;
				nse_pkg::CFG_REL_TOL: rel_tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.node_stall (node_stall),
		.node       (node),
		.push       (push),
		.work       (wr_work),
		.full       (full)
	);

	nse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_work),
		.full   (full),
		.pop    (pop),
		.rdata  (rd_work),
		.empty  (empty)
	);

	nse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.abs_tol   (abs_tol_q),
		.rel_tol   (rel_tol_q),
		.empty     (empty),
		.pop       (pop),
		.wdata     (rd_work),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
